// File: sv/tlcs_pkg.sv
// ----------------------------------------------------------------------------
// tlcs_pkg: shared types and byte classification for the connective splitter
// Holds the scan state, the result kinds, the character constants and the
// function that classifies the front byte of the lookahead window.
// ----------------------------------------------------------------------------
package tlcs_pkg;

  // Width of the signed parenthesis depth counter.
  localparam int DEPTH_BITS = 8;
  localparam int WIN_LEN    = 4;

  typedef logic signed [DEPTH_BITS-1:0] depth_t;

  localparam depth_t DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam depth_t DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_AND  = 2'd1,
    KIND_OR   = 2'd2,
    KIND_CONT = 2'd3
  } kind_t;

  localparam logic [7:0] CH_AMP    = 8'h26;  // &
  localparam logic [7:0] CH_BAR    = 8'h7C;  // |
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_O  = 8'h6F;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef struct packed {
    depth_t     depth;
    logic       in_quote;
    logic       quote_is_double;
    logic [7:0] prior_byte;
    logic       at_start;
    logic [1:0] skip_left;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    depth:           '0,
    in_quote:        1'b0,
    quote_is_double: 1'b0,
    prior_byte:      8'h00,
    at_start:        1'b1,
    skip_left:       2'd0
  };

  typedef struct packed {
    kind_t       kind;
    scan_state_t st;
  } cls_result_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_LOW_A && c <= CH_LOW_Z) ||
           (c >= CH_UP_A && c <= CH_UP_Z) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
  endfunction

  // Classifies w0 given the bytes that follow it; n counts the valid bytes
  // of the window (1 to 4), and nothing follows them when n is below 4.
  function automatic cls_result_t classify(input scan_state_t s,
                                           input logic [7:0] w0,
                                           input logic [7:0] w1,
                                           input logic [7:0] w2,
                                           input logic [7:0] w3,
                                           input logic [2:0] n);
    cls_result_t r;
    logic        left_ok;
    logic [7:0]  q;
    r.st    = s;
    r.kind  = KIND_TEXT;
    left_ok = s.at_start || !is_word_byte(s.prior_byte);
    q       = s.quote_is_double ? CH_DQUOTE : CH_SQUOTE;
    if (s.skip_left != 2'd0) begin
      r.st.skip_left = s.skip_left - 2'd1;
      r.kind         = KIND_CONT;
    end else if (s.in_quote) begin
      if (w0 == q && s.prior_byte != CH_BSLASH) r.st.in_quote = 1'b0;
    end else if (w0 == CH_SQUOTE || w0 == CH_DQUOTE) begin
      r.st.in_quote        = 1'b1;
      r.st.quote_is_double = (w0 == CH_DQUOTE);
    end else if (w0 == CH_LPAREN) begin
      if (s.depth != DEPTH_MAX) r.st.depth = s.depth + depth_t'(1);
    end else if (w0 == CH_RPAREN) begin
      if (s.depth != DEPTH_MIN) r.st.depth = s.depth - depth_t'(1);
    end else if (s.depth[DEPTH_BITS-1] || s.depth == '0) begin
      if (n >= 3'd2 && w0 == CH_AMP && w1 == CH_AMP) begin
        r.kind         = KIND_AND;
        r.st.skip_left = 2'd1;
      end else if (n >= 3'd2 && w0 == CH_BAR && w1 == CH_BAR) begin
        r.kind         = KIND_OR;
        r.st.skip_left = 2'd1;
      end else if (left_ok && n >= 3'd3 && fold(w0) == CH_LOW_A &&
                   fold(w1) == CH_LOW_N && fold(w2) == CH_LOW_D &&
                   (n < 3'd4 || !is_word_byte(w3))) begin
        r.kind         = KIND_AND;
        r.st.skip_left = 2'd2;
      end else if (left_ok && n >= 3'd2 && fold(w0) == CH_LOW_O &&
                   fold(w1) == CH_LOW_R && (n < 3'd3 || !is_word_byte(w2))) begin
        r.kind         = KIND_OR;
        r.st.skip_left = 2'd1;
      end
    end
    r.st.prior_byte = w0;
    r.st.at_start   = 1'b0;
    return r;
  endfunction

endpackage

// File: sv/top_level_connective_splitter_top.sv
// ----------------------------------------------------------------------------
// top_level_connective_splitter_top: top-level connective finder
// Classifies each byte of a filter expression as text, start of an AND,
// start of an OR, or a later byte of a connective, one byte per cycle while the input is not stalled.
// ----------------------------------------------------------------------------
// Results: a byte's result is registered at the transfer that brings the
//   third byte after it, or during the end-of-string drain.
// Throughput: one byte per cycle while the output takes results; after the
//   in_last transfer the input stalls; held bytes (one to four) drain alike.
// Reset: rst is synchronous and active high; it empties the window and
//   returns the scan state to the start of a string.
module top_level_connective_splitter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_char,
  output logic [1:0] kind,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_stall
);
  import tlcs_pkg::*;

  // The lookahead window: win[0] is the oldest byte. cnt counts the held
  // bytes; it stays at three or below inside a string and reaches four only
  // when the final byte lands and the drain begins.
  logic [7:0]  win [WIN_LEN];
  logic [2:0]  cnt;
  logic        flushing;
  scan_state_t st;

  logic        out_ready;
  logic        in_xfer;
  logic        emit_norm;
  logic        emit_flush;
  logic        emit;
  logic [7:0]  c0, c1, c2, c3;
  logic [2:0]  n_valid;
  cls_result_t cls;

  // The output register can take a new result when it is empty or when its
  // current result is being transferred in this cycle.
  assign out_ready = !out_valid || !out_stall;

  // Input is held off while draining, and when a full window would have to
  // emit a result that the output register cannot take.
  assign in_stall  = flushing || (cnt == 3'd3 && !out_ready);
  assign in_xfer   = in_valid && !in_stall;

  // In steady state the new byte completes the window and the front byte is
  // classified in the same cycle. During the drain, while the output can take
  // them, the held bytes go out one per cycle with the count of bytes held.
  assign emit_norm  = in_xfer && !in_last && cnt == 3'd3;
  assign emit_flush = flushing && out_ready;
  assign emit       = emit_norm || emit_flush;

  always_comb begin
    if (flushing) begin
      c0      = win[0];
      c1      = win[1];
      c2      = win[2];
      c3      = win[3];
      n_valid = cnt;
    end else begin
      c0      = win[0];
      c1      = win[1];
      c2      = win[2];
      c3      = in_char;
      n_valid = 3'd4;
    end
  end

  assign cls = classify(st, c0, c1, c2, c3, n_valid);

  // Window storage has no reset; cnt tells which entries hold bytes.
  always_ff @(posedge clk) begin
    if (emit_norm) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= in_char;
    end else if (in_xfer) begin
      win[cnt[1:0]] <= in_char;
    end else if (emit_flush) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
    end
  end

  // Control state: fill count, drain flag and the scan state. The scan
  // state returns to its start value once the last byte has been emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= 3'd0;
      flushing <= 1'b0;
      st       <= SCAN_RESET;
    end else if (emit_norm) begin
      st <= cls.st;
    end else if (in_xfer) begin
      cnt      <= cnt + 3'd1;
      flushing <= in_last;
    end else if (emit_flush) begin
      cnt <= cnt - 3'd1;
      if (cnt == 3'd1) begin
        flushing <= 1'b0;
        st       <= SCAN_RESET;
      end else begin
        st <= cls.st;
      end
    end
  end

  // Result register. It is loaded whenever it can take a result; its valid
  // flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && emit) begin
      out_char <= c0;
      kind     <= cls.kind;
      out_last <= emit_flush && cnt == 3'd1;
    end
  end

`ifndef SYNTHESIS
  // Outside a drain the window never holds a full four bytes.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    !flushing |-> cnt <= 3'd3)
    else $error("window count out of range outside a drain");

  // A drain always has at least one byte left to emit.
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    flushing |-> cnt != 3'd0)
    else $error("drain active with an empty window");

  // A final byte starts a drain in the next cycle.
  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_last) |=> flushing)
    else $error("final byte did not start a drain");

  // After the last byte of a string is emitted the scan state is back at
  // the start of a string.
  a_end_resets_scan: assert property (@(posedge clk) disable iff (rst)
    (emit_flush && cnt == 3'd1) |=> (st == SCAN_RESET && cnt == 3'd0))
    else $error("scan state not restored at end of string");

  // At most two continuation bytes follow the start of a connective.
  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    st.skip_left != 2'd3)
    else $error("continuation count out of range");
`endif

endmodule

// File: tb/tlcs_result_checker.sv
// ----------------------------------------------------------------------------
// tlcs_result_checker: scoreboard for the connective splitter
// Watches both channels, predicts the classification of every accepted byte
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlcs_result_checker
  import tlcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] out_char,
  input  logic [1:0] kind,
  input  logic       out_last,
  input  logic       out_valid,
  input  logic       out_stall,
  output int         errors,
  output int         pending,
  output int         checked,
  output int         connectives
);

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic       last;
  } byte_class_t;

  byte_class_t class_q[$];

  // Scan state of the predictor.
  logic [7:0]  win [WIN_LEN];
  int unsigned held;
  depth_t      nest;
  logic        quoted;
  logic        dq;
  logic [7:0]  prev;
  logic        fresh;
  logic [1:0]  skip;

  initial begin
    errors      = 0;
    pending     = 0;
    checked     = 0;
    connectives = 0;
  end

  function automatic logic word_char(input logic [7:0] c);
    if (c == CH_UNDER) return 1'b1;
    if (c >= CH_DIG_0 && c <= CH_DIG_9) return 1'b1;
    if (c >= CH_UP_A && c <= CH_UP_Z) return 1'b1;
    return c >= CH_LOW_A && c <= CH_LOW_Z;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return c + 8'd32;
    return c;
  endfunction

  task automatic clear_scan();
    held   = 0;
    nest   = '0;
    quoted = 1'b0;
    dq     = 1'b0;
    prev   = 8'h00;
    fresh  = 1'b1;
    skip   = 2'd0;
    for (int i = 0; i < WIN_LEN; i++) win[i] = 8'h00;
  endtask

  // Classifies the front of the window; n bytes of it are valid.
  task automatic classify_front(input int unsigned n, input logic fin);
    byte_class_t e;
    logic [7:0]  c;
    logic        left_clear;
    c          = win[0];
    e.ch       = c;
    e.kind     = KIND_TEXT;
    e.last     = fin;
    left_clear = fresh || !word_char(prev);
    if (skip != 2'd0) begin
      skip   = skip - 2'd1;
      e.kind = KIND_CONT;
    end else if (quoted) begin
      if (c == (dq ? CH_DQUOTE : CH_SQUOTE) && prev != CH_BSLASH) quoted = 1'b0;
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      quoted = 1'b1;
      dq     = (c == CH_DQUOTE);
    end else if (c == CH_LPAREN) begin
      if (nest != DEPTH_MAX) nest = nest + depth_t'(1);
    end else if (c == CH_RPAREN) begin
      if (nest != DEPTH_MIN) nest = nest - depth_t'(1);
    end else if (nest <= 0) begin
      if (n >= 2 && c == CH_AMP && win[1] == CH_AMP) begin
        e.kind = KIND_AND;
        skip   = 2'd1;
      end else if (n >= 2 && c == CH_BAR && win[1] == CH_BAR) begin
        e.kind = KIND_OR;
        skip   = 2'd1;
      end else if (left_clear && n >= 3 && lower(c) == CH_LOW_A &&
                   lower(win[1]) == CH_LOW_N && lower(win[2]) == CH_LOW_D &&
                   (n < 4 || !word_char(win[3]))) begin
        e.kind = KIND_AND;
        skip   = 2'd2;
      end else if (left_clear && n >= 2 && lower(c) == CH_LOW_O &&
                   lower(win[1]) == CH_LOW_R && (n < 3 || !word_char(win[2]))) begin
        e.kind = KIND_OR;
        skip   = 2'd1;
      end
    end
    prev    = c;
    fresh   = 1'b0;
    class_q = {class_q, e};
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
    win[WIN_LEN-1] = 8'h00;
  endtask

  task automatic take_byte(input logic [7:0] c, input logic fin);
    win[held] = c;
    held++;
    if (!fin) begin
      if (held == WIN_LEN) begin
        classify_front(WIN_LEN, 1'b0);
        held = WIN_LEN - 1;
      end
    end else begin
      while (held > 0) begin
        classify_front(held, held == 1);
        held--;
      end
      clear_scan();
    end
  endtask

  always @(posedge clk) begin : watch
    byte_class_t e;
    if (rst) begin
      clear_scan();
      class_q.delete();
    end else begin
      // Results go first; a result can never come from this edge's input.
      if (out_valid && !out_stall) begin
        if (class_q.size() == 0) begin
          errors++;
          $error("result with no prediction waiting: out_char %h kind %0d",
                 out_char, kind);
        end else begin
          e = class_q.pop_front();
          checked++;
          if (e.kind == KIND_AND || e.kind == KIND_OR) connectives++;
          if (out_char !== e.ch) begin
            errors++;
            $error("out_char: expected %h, actual %h", e.ch, out_char);
          end
          if (kind !== e.kind) begin
            errors++;
            $error("kind: expected %0d, actual %0d", e.kind, kind);
          end
          if (out_last !== e.last) begin
            errors++;
            $error("out_last: expected %0d, actual %0d", e.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall) take_byte(in_char, in_last);
    end
    pending = class_q.size();
  end

endmodule

// File: tb/tb_top_level_connective_splitter_top.sv
// ----------------------------------------------------------------------------
// tb_top_level_connective_splitter_top: testbench for the connective splitter
// Sends filter-expression strings, first a few hand-picked ones, then two
// long parenthesis runs that push the depth counter to both limits, then
// random strings built from connectives, words, quotes, parentheses and raw
// bytes. Both channels idle at random; a side checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top_level_connective_splitter_top;
  import tlcs_pkg::*;

  localparam int         RANDOM_BYTES   = 80;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] CH_SPACE       = 8'h20;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic [7:0] in_char   = 8'h00;
  logic       in_last   = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] out_char;
  logic [1:0] kind;
  logic       out_last;
  logic       out_valid;
  logic       out_stall = 1'b1;

  int errors;
  int pending;
  int checked;
  int connectives;

  // Bytes of the string being assembled, and run bookkeeping.
  logic [7:0] text_q[$];
  int         bytes_sent   = 0;
  int         strings_sent = 0;
  int         random_bytes = 0;
  int         quiet_cycles = 0;

  // When clear, the side in question never idles; they are redrawn per string
  // so that both busy stretches and back-to-back stretches occur.
  logic       tx_gaps = 1'b1;
  logic       rx_gaps = 1'b1;

  string      near_letters = "aAnNdDoOrR_";

  top_level_connective_splitter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_char   (in_char),
    .in_last   (in_last),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_char  (out_char),
    .kind      (kind),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  tlcs_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_char     (in_char),
    .in_last     (in_last),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_char    (out_char),
    .kind        (kind),
    .out_last    (out_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .connectives (connectives)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends the run when no transfer happens on either channel for
  // far longer than the worst legal stall: a drain of four results, each
  // held off for the longest sink hold, plus the longest sender gap.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: before each transfer the stall is held for a random number
  // of cycles, then dropped until a result is taken. Each assignment happens
  // at most once per edge.
  initial begin : result_sink
    int hold;
    forever begin
      hold = rx_gaps ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offers one byte after a random gap and returns once it has been
  // transferred. The values sampled right after the edge are the ones the
  // block saw at that edge, since every update lands in the NBA region.
  task automatic put_byte(input logic [7:0] c, input logic fin);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Appends one byte to the string being assembled.
  task automatic append_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  // Sends the assembled string with in_last on its final byte, then clears it
  // and redraws the idling style for the next string.
  task automatic send_string();
    for (int i = 0; i < text_q.size(); i++) put_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    strings_sent++;
    tx_gaps = ($urandom_range(0, 3) != 0);
    rx_gaps = ($urandom_range(0, 3) != 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // Appends a keyword with the case of every letter drawn at random.
  task automatic add_mixed_case(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ($urandom_range(0, 1)) c = c ^ CASE_BIT;
      append_byte(c);
    end
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0:       return CH_LOW_A + 8'($urandom_range(0, 25));
      1:       return CH_UP_A + 8'($urandom_range(0, 25));
      2:       return CH_DIG_0 + 8'($urandom_range(0, 9));
      default: return CH_UNDER;
    endcase
  endfunction

  // One token of a random expression. Most tokens are the pieces a real
  // filter is made of; the rest are raw bytes and stray symbols that test
  // the boundary rules and the handling of high bytes.
  task automatic add_token();
    int n;
    case ($urandom_range(0, 15))
      0:  add_text("&&");
      1:  add_text("||");
      2:  add_mixed_case("and");
      3:  add_mixed_case("or");
      4, 5: begin
        n = $urandom_range(1, 4);
        repeat (n) append_byte(word_byte());
      end
      6, 7: append_byte(CH_SPACE);
      8:  append_byte(CH_LPAREN);
      9:  append_byte(CH_RPAREN);
      10: append_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
      11: begin
        append_byte(CH_BSLASH);
        append_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
      end
      12: append_byte(8'($urandom_range(0, 255)));
      13: append_byte($urandom_range(0, 1) ? CH_AMP : CH_BAR);
      14: append_byte(near_letters[$urandom_range(0, near_letters.len() - 1)]);
      default: append_byte(8'($urandom_range(128, 255)));
    endcase
  endtask

  initial begin : stimulus
    int tokens;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings. A lone all-ones byte is the shortest possible string.
    append_byte(8'hFF);
    send_string();
    // Keywords that fill the whole string: the string end is the right
    // boundary and the string start the left one; both letter cases.
    add_text("Or");
    send_string();
    add_text("AnD");
    send_string();
    // Symbol connectives between words.
    add_text("x||y&&z");
    send_string();
    // An escaped quote keeps the literal open, so the keyword inside is text.
    add_text("'\\'and'");
    send_string();
    // A zero byte, a surplus ')' (negative depth still counts as top level)
    // and a high byte acting as a word boundary.
    append_byte(8'h00);
    add_text(")or");
    append_byte(8'h80);
    send_string();

    // Depth saturation at the top: after 129 opens the counter must sit at
    // its maximum, so the keyword that follows is still nested and is text.
    repeat (129) append_byte(CH_LPAREN);
    add_text(" or");
    send_string();
    // Depth saturation at the bottom.
    repeat (130) append_byte(CH_RPAREN);
    add_text(" or");
    send_string();

    // Random expressions.
    while (random_bytes < RANDOM_BYTES) begin
      tokens = $urandom_range(1, 6);
      repeat (tokens) add_token();
      random_bytes += text_q.size();
      send_string();
    end
    in_valid <= 1'b0;

    // Drain: the watchdog catches results that never arrive. One edge first,
    // so that the count includes the bytes of the final transfer.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d strings (%0d bytes) with random gaps on both channels.",
             strings_sent, bytes_sent);
    $display("Checked %0d classified bytes, %0d of them connective starts.",
             checked, connectives);
    if (pending != 0) $error("%0d predicted results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
